// ===== src/iar_pkg.sv =====
package iar_pkg;

    localparam logic [2:0] FMT_SDEC = 3'd0;
    localparam logic [2:0] FMT_UDEC = 3'd1;
    localparam logic [2:0] FMT_OCT  = 3'd2;
    localparam logic [2:0] FMT_LHEX = 3'd3;
    localparam logic [2:0] FMT_UHEX = 3'd4;

    localparam int unsigned VALUE_W  = 64;
    localparam int unsigned SLOTS    = 22;
    localparam int unsigned SLOT_W   = 5;
    localparam logic [6:0]  DAB_STEPS = 7'd64;
    localparam logic [4:0]  DEC_DIGITS = 5'd20;
    localparam logic [4:0]  OCT_DIGITS = 5'd22;
    localparam logic [4:0]  HEX_DIGITS = 5'd16;
    localparam logic [6:0]  CHAR_MINUS = 7'h2d;

    typedef struct packed {
        logic [63:0] value;
        logic [2:0]  format;
    } t_in;

    typedef struct packed {
        logic [6:0] character;
        logic       last;
    } t_out;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SIGN,
        ST_SCAN,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic dab;
        logic sign;
        logic skip;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic top_zero;
        logic rem_one;
        logic dab_last;
        logic neg;
    } t_status;

    function automatic logic [6:0] digit_char(input logic [3:0] d, input logic upper);
        logic [6:0] c;
        if (d < 4'd10) begin
            c = 7'h30 + {3'b000, d};
        end else if (upper) begin
            c = 7'h41 + {3'b000, d} - 7'd10;
        end else begin
            c = 7'h61 + {3'b000, d} - 7'd10;
        end
        return c;
    endfunction

endpackage

// ===== src/integer_to_ascii_radix_core.sv =====
// Converts a 64-bit value to ASCII characters, most significant first, one per strobed
// result, with the final character flagged by last. Decimal formats run a shift-and-add-3
// binary to BCD loop over all 64 bits of the value, and a decimal item keeps busy high
// through that loop, the minus sign of a negative value, the skipped leading zeros and
// the emitted digits; octal and hex are sliced straight into digits and skip the loop.
// Results come out one per cycle at most and the receiver cannot stall: every strobe
// is a taken result. Format codes 5 to 7 are accepted and produce nothing.
module integer_to_ascii_radix_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    input  iar_pkg::t_in   i_data,
    output logic           busy,
    output iar_pkg::t_out  o_result,
    output logic           o_strobe
);

    iar_pkg::t_cmd    cmd;
    iar_pkg::t_status status;

    iar_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_format (i_data.format),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    iar_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_data   (i_data),
        .i_cmd    (cmd),
        .o_status (status),
        .o_result (o_result),
        .o_strobe (o_strobe)
    );

`ifndef NO_ASSERTIONS
    a_mid_run_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_result.last |-> busy)
        else $error("character without last while idle");

    a_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_result.last |=> !o_strobe)
        else $error("character after end of run");

    a_bad_format_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (i_data.format > iar_pkg::FMT_UHEX) |=> !busy && !o_strobe)
        else $error("unused format started a run");
`endif

endmodule

// ===== src/iar_ctrl.sv =====
module iar_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [2:0]        i_format,
    input  iar_pkg::t_status  i_status,
    output iar_pkg::t_cmd     o_cmd,
    output logic              o_busy
);

    iar_pkg::t_state r_state;
    iar_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= iar_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            iar_pkg::ST_IDLE: begin
                if (i_start && (i_format <= iar_pkg::FMT_UHEX)) begin
                    o_cmd.load = 1'b1;
                    if (i_format == iar_pkg::FMT_SDEC || i_format == iar_pkg::FMT_UDEC) begin
                        n_state = iar_pkg::ST_CONV;
                    end else begin
                        n_state = iar_pkg::ST_SCAN;
                    end
                end
            end
            iar_pkg::ST_CONV: begin
                o_cmd.dab = 1'b1;
                if (i_status.dab_last) begin
                    n_state = i_status.neg ? iar_pkg::ST_SIGN : iar_pkg::ST_SCAN;
                end
            end
            iar_pkg::ST_SIGN: begin
                o_cmd.sign = 1'b1;
                n_state    = iar_pkg::ST_SCAN;
            end
            iar_pkg::ST_SCAN: begin
                if (i_status.top_zero && !i_status.rem_one) begin
                    o_cmd.skip = 1'b1;
                end else begin
                    n_state = iar_pkg::ST_EMIT;
                end
            end
            iar_pkg::ST_EMIT: begin
                o_cmd.emit = 1'b1;
                if (i_status.rem_one) begin
                    n_state = iar_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = iar_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != iar_pkg::ST_IDLE);

endmodule

// ===== src/iar_dp.sv =====
module iar_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  iar_pkg::t_in      i_data,
    input  iar_pkg::t_cmd     i_cmd,
    output iar_pkg::t_status  o_status,
    output iar_pkg::t_out     o_result,
    output logic              o_strobe
);

    logic [iar_pkg::SLOTS-1:0][3:0] r_dig;
    logic [iar_pkg::SLOTS-1:0][3:0] n_dig;
    logic [iar_pkg::SLOTS-1:0][3:0] adj;
    logic [iar_pkg::SLOTS*4-1:0]    flat;
    logic [iar_pkg::VALUE_W-1:0]    r_bin;
    logic [iar_pkg::VALUE_W-1:0]    mag;
    logic [6:0]                     r_cnt;
    logic [iar_pkg::SLOT_W-1:0]     r_rem;
    logic                           r_neg;
    logic                           r_upper;
    logic                           in_neg;
    iar_pkg::t_out                  r_result;
    logic                           r_strobe;

    assign in_neg = (i_data.format == iar_pkg::FMT_SDEC) && i_data.value[63];
    assign mag    = in_neg ? (~i_data.value + 64'd1) : i_data.value;

    always_comb begin
        for (int i = 0; i < iar_pkg::SLOTS; i++) begin
            adj[i] = (r_dig[i] >= 4'd5) ? (r_dig[i] + 4'd3) : r_dig[i];
        end
        flat = adj;
    end

    always_comb begin
        n_dig = '0;
        case (i_data.format)
            iar_pkg::FMT_OCT: begin
                for (int i = 0; i < iar_pkg::SLOTS - 1; i++) begin
                    n_dig[i] = {1'b0, i_data.value[3*i +: 3]};
                end
                n_dig[iar_pkg::SLOTS-1] = {3'b000, i_data.value[63]};
            end
            iar_pkg::FMT_LHEX, iar_pkg::FMT_UHEX: begin
                for (int i = 0; i < 16; i++) begin
                    n_dig[i + 6] = i_data.value[4*i +: 4];
                end
            end
            default: begin
                n_dig = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_dig   <= n_dig;
            r_bin   <= mag;
            r_neg   <= in_neg;
            r_upper <= (i_data.format == iar_pkg::FMT_UHEX);
            r_cnt   <= iar_pkg::DAB_STEPS;
            case (i_data.format)
                iar_pkg::FMT_OCT:                     r_rem <= iar_pkg::OCT_DIGITS;
                iar_pkg::FMT_LHEX, iar_pkg::FMT_UHEX: r_rem <= iar_pkg::HEX_DIGITS;
                default:                              r_rem <= iar_pkg::DEC_DIGITS;
            endcase
        end else if (i_cmd.dab) begin
            r_dig <= {flat[86:8], r_bin[63], flat[7:0]};
            r_bin <= {r_bin[62:0], 1'b0};
            r_cnt <= r_cnt - 7'd1;
        end else if (i_cmd.skip || i_cmd.emit) begin
            r_dig <= {r_dig[iar_pkg::SLOTS-2:0], 4'h0};
            r_rem <= r_rem - 5'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.sign || i_cmd.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sign) begin
            r_result.character <= iar_pkg::CHAR_MINUS;
            r_result.last      <= 1'b0;
        end else if (i_cmd.emit) begin
            r_result.character <= iar_pkg::digit_char(r_dig[iar_pkg::SLOTS-1], r_upper);
            r_result.last      <= (r_rem == 5'd1);
        end
    end

    assign o_status.top_zero = (r_dig[iar_pkg::SLOTS-1] == 4'h0);
    assign o_status.rem_one  = (r_rem == 5'd1);
    assign o_status.dab_last = (r_cnt == 7'd1);
    assign o_status.neg      = r_neg;
    assign o_result          = r_result;
    assign o_strobe          = r_strobe;

endmodule

// ===== test/integer_to_ascii_radix_core_tb.sv =====
`timescale 1ns / 1ps

module integer_to_ascii_radix_core_tb;
    import iar_pkg::*;

    localparam logic [2:0] FMT_RSVD_A = 3'd5;
    localparam logic [2:0] FMT_RSVD_B = 3'd6;
    localparam logic [2:0] FMT_RSVD_C = 3'd7;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic start;
    t_in  i_data;
    logic busy;
    t_out o_result;
    logic o_strobe;

    t_out        pending_chars[$];
    int unsigned errors = 0;
    int unsigned items_sent = 0;
    int unsigned ignored_items = 0;
    int unsigned chars_seen = 0;
    int unsigned sender_idle_pct = 0;

    integer_to_ascii_radix_core DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_data   (i_data),
        .busy     (busy),
        .o_result (o_result),
        .o_strobe (o_strobe)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Expected characters of one item, most significant first
    function automatic int convert_item(input t_in item);
        logic [63:0] mag;
        logic [63:0] radix;
        logic [6:0]  rev [0:21];
        logic [3:0]  d;
        logic        upper;
        t_out        c;
        int          n;
        int          count;
        mag   = item.value;
        upper = 1'b0;
        n     = 0;
        count = 0;
        case (item.format)
            FMT_SDEC, FMT_UDEC: radix = 64'd10;
            FMT_OCT:            radix = 64'd8;
            FMT_LHEX:           radix = 64'd16;
            FMT_UHEX: begin
                radix = 64'd16;
                upper = 1'b1;
            end
            default: return 0;
        endcase
        if (item.format == FMT_SDEC && mag[63]) begin
            c.character = CHAR_MINUS;
            c.last      = 1'b0;
            pending_chars.push_back(c);
            count = 1;
            mag   = ~mag + 64'd1;
        end
        do begin
            d = 4'(mag % radix);
            if (d < 4'd10) begin
                rev[n] = 7'h30 + 7'(d);
            end else if (upper) begin
                rev[n] = 7'h37 + 7'(d);
            end else begin
                rev[n] = 7'h57 + 7'(d);
            end
            mag = mag / radix;
            n++;
        end while (mag != 64'd0 && n < 22);
        for (int k = n - 1; k >= 0; k--) begin
            c.character = rev[k];
            c.last      = (k == 0);
            pending_chars.push_back(c);
        end
        return count + n;
    endfunction

    function automatic logic [63:0] random_value();
        logic [63:0] v;
        logic [63:0] mask;
        int          w;
        v    = {$urandom, $urandom};
        w    = $urandom_range(64, 1);
        mask = (w == 64) ? '1 : ((64'd1 << w) - 64'd1);
        case ($urandom_range(9))
            0, 1:    v = v;
            2:       v = ~(v & mask);
            3:       v = 64'($urandom_range(9));
            default: v = v & mask;
        endcase
        return v;
    endfunction

    task automatic send_item(input t_in item);
        int n;
        start  <= 1'b1;
        i_data <= item;
        do @(posedge i_clk); while (busy !== 1'b0);
        n = convert_item(item);
        items_sent++;
        if (n == 0) ignored_items++;
    endtask

    task automatic sender_gap();
        int n;
        n = 0;
        while (n < 40 && $urandom_range(99) < sender_idle_pct) n++;
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic wait_for_drain();
        start <= 1'b0;
        do @(posedge i_clk); while (pending_chars.size() != 0);
    endtask

    task automatic test_directed();
        t_in items [$];
        items = '{
            '{64'd0, FMT_SDEC}, '{64'd0, FMT_UDEC}, '{64'd0, FMT_OCT},
            '{64'd0, FMT_LHEX}, '{64'd0, FMT_UHEX},
            '{'1, FMT_SDEC}, '{'1, FMT_UDEC}, '{'1, FMT_OCT},
            '{'1, FMT_LHEX}, '{'1, FMT_UHEX},
            '{64'h8000_0000_0000_0000, FMT_SDEC}, '{64'h8000_0000_0000_0000, FMT_UDEC},
            '{64'h8000_0000_0000_0000, FMT_OCT},
            '{64'h7FFF_FFFF_FFFF_FFFF, FMT_SDEC}, '{64'd1, FMT_SDEC},
            '{64'd9999999999999999999, FMT_UDEC}, '{64'd10000000000000000000, FMT_UDEC},
            '{64'hFEDC_BA98_7654_3210, FMT_LHEX}, '{64'hFEDC_BA98_7654_3210, FMT_UHEX},
            '{'1, FMT_RSVD_A}, '{64'h1234_5678_9ABC_DEF0, FMT_RSVD_B}, '{64'd0, FMT_RSVD_C}
        };
        foreach (items[i]) begin
            sender_gap();
            send_item(items[i]);
        end
        wait_for_drain();
    endtask

    task automatic test_random_items(input int unsigned pct, input int count);
        t_in item;
        int  done;
        sender_idle_pct = pct;
        done = 0;
        while (done < count) begin
            sender_gap();
            item.value = random_value();
            if ($urandom_range(99) < 6) begin
                item.format = 3'($urandom_range(FMT_RSVD_C, FMT_RSVD_A));
            end else begin
                item.format = 3'($urandom_range(FMT_UHEX, FMT_SDEC));
            end
            send_item(item);
            if (item.format <= FMT_UHEX) done++;
        end
        wait_for_drain();
    endtask

    task automatic test_pause_until_drained();
        t_in item;
        sender_idle_pct = 0;
        repeat (4) begin
            item.value  = random_value();
            item.format = 3'($urandom_range(FMT_UHEX, FMT_SDEC));
            send_item(item);
        end
        wait_for_drain();
        item.value  = '1;
        item.format = FMT_OCT;
        send_item(item);
        wait_for_drain();
    endtask

    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n === 1'b1 && o_strobe === 1'b1) begin
            chars_seen++;
            if (pending_chars.size() == 0) begin
                $error("unexpected result: character %h last %b",
                       o_result.character, o_result.last);
                errors++;
            end else begin
                want = pending_chars.pop_front();
                if (o_result.character !== want.character) begin
                    $error("character: expected %h, actual %h",
                           want.character, o_result.character);
                    errors++;
                end
                if (o_result.last !== want.last) begin
                    $error("last: expected %b, actual %b", want.last, o_result.last);
                    errors++;
                end
            end
        end
    end

    initial begin
        i_rst_n <= 1'b0;
        start   <= 1'b0;
        i_data  <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        sender_idle_pct = 16;
        test_directed();
        test_random_items(16, 95);
        test_pause_until_drained();
        test_random_items(88, 95);
        test_random_items(0, 95);
        start <= 1'b0;
        while (pending_chars.size() != 0) @(posedge i_clk);
        repeat (150) @(posedge i_clk);
        $display("Sent %0d items (%0d with unused format codes), checked %0d characters",
                 items_sent, ignored_items, chars_seen);
        $display("across all five formats, sender gaps of 16%%, 88%% and none, one full drain.");
        if (errors == 0 && pending_chars.size() == 0) begin
            $display("integer_to_ascii_radix_core_tb passed");
        end else begin
            $display("integer_to_ascii_radix_core_tb failed");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("integer_to_ascii_radix_core_tb failed");
        $finish;
    end

endmodule
